FILE: rtl/core/iitl_pkg.sv
// Shared codes, widths and types of the ideal index table lookup engine.
package iitl_pkg;

  localparam int FIELD_BITS = 32;
  localparam int INDEX_BITS = 16;
  localparam int STATUS_BITS = 3;
  localparam int OP_BITS = 2;
  localparam int CFG_ADDR_BITS = 3;
  localparam int SIDE_MODE_BITS = 2;
  localparam int CACHE_LIMIT_BITS = 13;
  localparam int IN_DATA_BITS = 104;
  localparam int OUT_DATA_BITS = 24;

  localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_BITS-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_BITS-1:0] OP_LOOKUP = 2'd2;

  localparam logic [STATUS_BITS-1:0] ST_OK = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_CACHE_MISMATCH = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_ABOVE_BOUND = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_TABLE_FULL = 3'd4;

  localparam logic [CFG_ADDR_BITS-1:0] REG_SIDE_MODE = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_SPECIAL_VALUE = 3'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_CACHE_LIMIT = 3'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_PRIME_BOUND_ZERO = 3'd3;
  localparam logic [CFG_ADDR_BITS-1:0] REG_PRIME_BOUND_ONE = 3'd4;

  localparam logic [SIDE_MODE_BITS-1:0] MODE_RAT_ZERO = 2'd1;
  localparam logic [SIDE_MODE_BITS-1:0] MODE_RAT_ONE = 2'd2;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

endpackage

FILE: rtl/core/ideal_index_table_lookup.sv
// Top level: sequencer of the ideal index table lookup engine.
// An append, a clear (with its cache sweep) and a lookup (with its binary search
// steps, rewind reads and run walk steps) each run to the end before the next item
// is accepted; one item is in work at a time.
// The rate is set by the single read port of the entry memory and the compare unit.
// After reset the start cache is swept to zero before the first item is accepted;
// a clear repeats that sweep.
module ideal_index_table_lookup #(
  parameter int TABLE_LOG = 16,
  parameter int CACHE_LOG = 12,
  parameter int VALUE_BITS = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [iitl_pkg::CFG_ADDR_BITS-1:0]     cfg_addr_i,
  input  logic [iitl_pkg::FIELD_BITS-1:0]        cfg_data_i,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // entry_value[31:0], prime[63:32], root[95:64], side[96], zero fill above.
  input  logic [iitl_pkg::IN_DATA_BITS-1:0]      s_axis_tdata,
  // op[1:0].
  input  logic [iitl_pkg::OP_BITS-1:0]           s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // index[15:0], status[18:16], zero fill above.
  output logic [iitl_pkg::OUT_DATA_BITS-1:0]     m_axis_tdata
);

  localparam int TW = TABLE_LOG;
  localparam int CW = TABLE_LOG + 1;
  localparam int CAW = CACHE_LOG + 1;
  localparam int VW = VALUE_BITS;
  localparam int SEARCH_LIMIT = 2 * TABLE_LOG + 8;
  localparam int SW = $clog2(SEARCH_LIMIT + 1);
  localparam int FB = iitl_pkg::FIELD_BITS;

  typedef enum logic [19:0] {
    S_CLR  = 20'h00001,
    S_IDLE = 20'h00002,
    S_APP1 = 20'h00004,
    S_APP2 = 20'h00008,
    S_APP3 = 20'h00010,
    S_APP4 = 20'h00020,
    S_LK1  = 20'h00040,
    S_LK2  = 20'h00080,
    S_LK3  = 20'h00100,
    S_LKC  = 20'h00200,
    S_LKV  = 20'h00400,
    S_SRI  = 20'h00800,
    S_RWI  = 20'h01000,
    S_RWC  = 20'h02000,
    S_RWP  = 20'h04000,
    S_CMP  = 20'h08000,
    S_WK   = 20'h10000,
    S_WKA  = 20'h20000,
    S_WKB  = 20'h40000,
    S_OUT  = 20'h80000
  } state_e;

  state_e state_q, state_d;

  logic [iitl_pkg::SIDE_MODE_BITS-1:0]   side_mode_q;
  logic [FB-1:0]                         special_q;
  logic [iitl_pkg::CACHE_LIMIT_BITS-1:0] cache_limit_q;
  logic [FB-1:0]                         bound_zero_q;
  logic [FB-1:0]                         bound_one_q;

  logic [CW-1:0]  cnt_q, cnt_d;
  logic           seen_q, seen_d;
  logic [TW-1:0]  fu_idx_q, fu_idx_d;
  logic [VW-1:0]  fu_prime_q, fu_prime_d;
  logic [TW-1:0]  bidx_q [2];
  logic [TW-1:0]  bidx_d [2];
  logic [VW-1:0]  bprime_q [2];
  logic [VW-1:0]  bprime_d [2];
  logic [CAW-1:0] clr_q, clr_d;
  logic           clr_resp_q, clr_resp_d;
  logic [CW-1:0]  idx_q, idx_d;
  logic [iitl_pkg::STATUS_BITS-1:0] status_q, status_d;

  logic [VW-1:0]  val_q, val_d;
  logic [VW-1:0]  p_q, p_d;
  logic [FB-1:0]  r_q, r_d;
  logic           side_q, side_d;
  logic [VW-1:0]  vp_q, vp_d;
  logic [VW-1:0]  vr_q, vr_d;
  logic [VW-1:0]  cur_q, cur_d;
  logic [VW-1:0]  nxt_q, nxt_d;
  logic [VW-1:0]  last_q, last_d;
  logic [CW-1:0]  i_q, i_d;
  logic [TW-1:0]  lo_q, lo_d;
  logic [TW-1:0]  hi_q, hi_d;
  logic [TW-1:0]  old_q, old_d;
  logic [SW-1:0]  step_q, step_d;
  logic           first_q, first_d;

  logic           ent_we;
  logic [TW-1:0]  ent_waddr;
  logic [TW-1:0]  ent_raddr;
  logic [VW-1:0]  ent_rdata;
  logic           cache_we;
  logic [CAW-1:0] cache_waddr;
  logic [TW-1:0]  cache_wdata;
  logic [CAW-1:0] cache_raddr;
  logic [TW-1:0]  cache_rdata;

  logic [VW-1:0]  cmp_a, cmp_b;
  iitl_pkg::cmp_res_t cmp_res;

  logic           rat_valid;
  logic           rat_side;
  logic           side_is_rat;
  logic [VW-1:0]  special_ext;
  logic [VW:0]    vp2;
  logic [VW-1:0]  vp_calc, vr_calc, prime_calc;
  logic           p_cacheable;
  logic [CW-1:0]  cnt_m1;
  logic [TW:0]    sri_sum, up_sum, dn_sum;
  logic [TW-1:0]  sri_mid, sri_i, up_mid, dn_mid;
  logic [CW-1:0]  up_i, dn_i, new_i;
  logic           dn_fail;
  logic           accept;

  iitl_ram #(.WIDTH(VW), .DEPTH(2 ** TW)) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (val_q),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  iitl_ram #(.WIDTH(TW), .DEPTH(2 ** CAW)) u_cache_ram (
    .clk_i   (clk_i),
    .we_i    (cache_we),
    .waddr_i (cache_waddr),
    .wdata_i (cache_wdata),
    .raddr_i (cache_raddr),
    .rdata_o (cache_rdata)
  );

  iitl_cmp #(.W(VW)) u_cmp (
    .a_i   (cmp_a),
    .b_i   (cmp_b),
    .res_o (cmp_res)
  );

  assign rat_valid = (side_mode_q == iitl_pkg::MODE_RAT_ZERO) ||
                     (side_mode_q == iitl_pkg::MODE_RAT_ONE);
  assign rat_side = (side_mode_q == iitl_pkg::MODE_RAT_ONE);
  assign side_is_rat = rat_valid && (side_q == rat_side);
  assign special_ext = VW'(special_q);
  assign vp2 = {p_q, 1'b1};
  assign vp_calc = rat_valid ? (p_q + VW'(1)) : vp2[VW-1:0];
  assign vr_calc = rat_valid ? (side_is_rat ? vp_calc : VW'(r_q)) :
                   (side_q ? (p_q + VW'(1) + VW'(r_q)) : VW'(r_q));
  assign prime_calc = rat_valid ? (val_q - VW'(1)) : (val_q >> 1);
  assign p_cacheable = (p_q >> CAW) == '0;
  assign cnt_m1 = cnt_q - CW'(1);

  assign sri_sum = {1'b0, fu_idx_q} + {1'b0, bidx_q[side_q]};
  assign sri_mid = sri_sum[TW:1];
  assign sri_i = (sri_mid < fu_idx_q) ? fu_idx_q :
                 ((sri_mid > bidx_q[side_q]) ? bidx_q[side_q] : sri_mid);
  assign up_sum = {1'b0, old_q} + {1'b0, hi_q};
  assign up_mid = up_sum[TW:1];
  assign up_i = (up_mid == old_q) ? ({1'b0, up_mid} + CW'(1)) : {1'b0, up_mid};
  assign dn_sum = {1'b0, old_q} + {1'b0, lo_q};
  assign dn_mid = dn_sum[TW:1];
  assign dn_fail = (dn_mid == old_q) && (dn_mid == '0);
  assign dn_i = (dn_mid == old_q) ? ({1'b0, dn_mid} - CW'(1)) : {1'b0, dn_mid};
  assign new_i = cmp_res.lt ? up_i : dn_i;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata = {{(iitl_pkg::OUT_DATA_BITS - iitl_pkg::INDEX_BITS -
                           iitl_pkg::STATUS_BITS){1'b0}},
                         status_q, iitl_pkg::INDEX_BITS'(idx_q)};

  always_comb begin
    cmp_a = '0;
    cmp_b = '0;
    case (state_q)
      S_APP1: begin
        cmp_a = last_q;
        cmp_b = val_q;
      end
      S_APP2: begin
        cmp_a = p_q;
        cmp_b = VW'(cache_limit_q);
      end
      S_APP3: begin
        cmp_a = VW'(bound_zero_q);
        cmp_b = p_q;
      end
      S_APP4: begin
        cmp_a = VW'(bound_one_q);
        cmp_b = p_q;
      end
      S_LK2: begin
        cmp_a = p_q;
        cmp_b = fu_prime_q;
      end
      S_LK3: begin
        cmp_a = bprime_q[side_q];
        cmp_b = p_q;
      end
      S_RWP: begin
        cmp_a = cur_q;
        cmp_b = ent_rdata;
      end
      S_CMP: begin
        cmp_a = cur_q;
        cmp_b = vp_q;
      end
      S_WKA: begin
        cmp_a = ent_rdata;
        cmp_b = cur_q;
      end
      S_WKB: begin
        cmp_a = nxt_q;
        cmp_b = vr_q;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    seen_d = seen_q;
    fu_idx_d = fu_idx_q;
    fu_prime_d = fu_prime_q;
    bidx_d = bidx_q;
    bprime_d = bprime_q;
    clr_d = clr_q;
    clr_resp_d = clr_resp_q;
    idx_d = idx_q;
    status_d = status_q;
    val_d = val_q;
    p_d = p_q;
    r_d = r_q;
    side_d = side_q;
    vp_d = vp_q;
    vr_d = vr_q;
    cur_d = cur_q;
    nxt_d = nxt_q;
    last_d = last_q;
    i_d = i_q;
    lo_d = lo_q;
    hi_d = hi_q;
    old_d = old_q;
    step_d = step_q;
    first_d = first_q;
    ent_we = 1'b0;
    ent_waddr = cnt_q[TW-1:0];
    ent_raddr = '0;
    cache_we = 1'b0;
    cache_waddr = clr_q;
    cache_wdata = '0;
    cache_raddr = p_q[CAW-1:0];

    case (state_q)
      S_CLR: begin
        cache_we = 1'b1;
        clr_d = clr_q + CAW'(1);
        if (clr_q == '1) begin
          idx_d = '0;
          status_d = iitl_pkg::ST_OK;
          state_d = clr_resp_q ? S_OUT : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          val_d = VW'(s_axis_tdata[FB-1:0]);
          p_d = VW'(s_axis_tdata[2*FB-1:FB]);
          r_d = s_axis_tdata[3*FB-1:2*FB];
          side_d = s_axis_tdata[3*FB];
          idx_d = '0;
          status_d = iitl_pkg::ST_OK;
          case (s_axis_tuser)
            iitl_pkg::OP_CLEAR: begin
              cnt_d = '0;
              seen_d = 1'b0;
              fu_idx_d = '0;
              fu_prime_d = VW'({FB{1'b1}});
              bidx_d[0] = '0;
              bidx_d[1] = '0;
              bprime_d[0] = '0;
              bprime_d[1] = '0;
              clr_d = '0;
              clr_resp_d = 1'b1;
              state_d = S_CLR;
            end
            iitl_pkg::OP_APPEND: state_d = S_APP1;
            iitl_pkg::OP_LOOKUP: state_d = S_LK1;
            default: state_d = S_OUT;
          endcase
        end
      end
      S_APP1: begin
        if (cnt_q[TW]) begin
          status_d = iitl_pkg::ST_TABLE_FULL;
          state_d = S_OUT;
        end else begin
          ent_we = 1'b1;
          last_d = val_q;
          idx_d = cnt_q;
          cnt_d = cnt_q + CW'(1);
          p_d = prime_calc;
          if ((val_q != special_ext) &&
              ((cnt_q == '0) || (last_q == special_ext) || cmp_res.lt)) begin
            state_d = S_APP2;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_APP2: begin
        if (cmp_res.lt && p_cacheable) begin
          cache_we = 1'b1;
          cache_waddr = p_q[CAW-1:0];
          cache_wdata = idx_q[TW-1:0];
        end else if (!seen_q) begin
          seen_d = 1'b1;
          fu_idx_d = idx_q[TW-1:0];
          fu_prime_d = p_q;
        end
        state_d = S_APP3;
      end
      S_APP3: begin
        if (!cmp_res.lt) begin
          bidx_d[0] = idx_q[TW-1:0];
          bprime_d[0] = p_q;
        end
        state_d = S_APP4;
      end
      S_APP4: begin
        if (!cmp_res.lt) begin
          bidx_d[1] = idx_q[TW-1:0];
          bprime_d[1] = p_q;
        end
        state_d = S_OUT;
      end
      S_LK1: begin
        vp_d = vp_calc;
        vr_d = vr_calc;
        state_d = S_LK2;
      end
      S_LK2: begin
        if (cmp_res.lt) begin
          if (!p_cacheable) begin
            status_d = iitl_pkg::ST_CACHE_MISMATCH;
            state_d = S_OUT;
          end else begin
            state_d = S_LKC;
          end
        end else begin
          state_d = S_LK3;
        end
      end
      S_LK3: begin
        if (cmp_res.lt) begin
          status_d = iitl_pkg::ST_ABOVE_BOUND;
          state_d = S_OUT;
        end else begin
          state_d = S_SRI;
        end
      end
      S_LKC: begin
        if ({1'b0, cache_rdata} >= cnt_q) begin
          status_d = iitl_pkg::ST_CACHE_MISMATCH;
          state_d = S_OUT;
        end else begin
          ent_raddr = cache_rdata;
          i_d = {1'b0, cache_rdata};
          state_d = S_LKV;
        end
      end
      S_LKV: begin
        if (ent_rdata != vp_q) begin
          status_d = iitl_pkg::ST_CACHE_MISMATCH;
          state_d = S_OUT;
        end else begin
          cur_d = vp_q;
          first_d = 1'b1;
          state_d = S_WK;
        end
      end
      S_SRI: begin
        if ((cnt_q == '0) || ({1'b0, fu_idx_q} >= cnt_q) ||
            ({1'b0, bidx_q[side_q]} >= cnt_q)) begin
          status_d = iitl_pkg::ST_NOT_FOUND;
          state_d = S_OUT;
        end else begin
          lo_d = fu_idx_q;
          hi_d = bidx_q[side_q];
          i_d = {1'b0, sri_i};
          old_d = sri_i;
          step_d = '0;
          state_d = S_RWI;
        end
      end
      S_RWI: begin
        ent_raddr = i_q[TW-1:0];
        state_d = S_RWC;
      end
      S_RWC: begin
        cur_d = ent_rdata;
        if (i_q == '0) begin
          state_d = S_CMP;
        end else begin
          ent_raddr = i_q[TW-1:0] - TW'(1);
          state_d = S_RWP;
        end
      end
      S_RWP: begin
        if (cmp_res.lt) begin
          i_d = i_q - CW'(1);
          cur_d = ent_rdata;
          if (i_q == CW'(1)) begin
            state_d = S_CMP;
          end else begin
            ent_raddr = i_q[TW-1:0] - TW'(2);
            state_d = S_RWP;
          end
        end else begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (cmp_res.eq) begin
          first_d = 1'b1;
          state_d = S_WK;
        end else begin
          if (cmp_res.lt) begin
            lo_d = old_q;
          end else begin
            hi_d = old_q;
          end
          if ((!cmp_res.lt && dn_fail) || (new_i >= cnt_q) ||
              (step_q == SW'(SEARCH_LIMIT - 1))) begin
            status_d = iitl_pkg::ST_NOT_FOUND;
            state_d = S_OUT;
          end else begin
            i_d = new_i;
            old_d = new_i[TW-1:0];
            step_d = step_q + SW'(1);
            state_d = S_RWI;
          end
        end
      end
      S_WK: begin
        if (first_q && side_is_rat) begin
          idx_d = i_q;
          state_d = S_OUT;
        end else if (i_q == cnt_m1) begin
          if (first_q) begin
            idx_d = i_q;
          end else begin
            status_d = iitl_pkg::ST_NOT_FOUND;
          end
          state_d = S_OUT;
        end else begin
          ent_raddr = i_q[TW-1:0] + TW'(1);
          state_d = S_WKA;
        end
      end
      S_WKA: begin
        nxt_d = ent_rdata;
        if (!cmp_res.lt) begin
          if (first_q) begin
            idx_d = i_q;
          end else begin
            status_d = iitl_pkg::ST_NOT_FOUND;
          end
          state_d = S_OUT;
        end else if (first_q) begin
          state_d = S_WKB;
        end else begin
          i_d = i_q + CW'(1);
          cur_d = ent_rdata;
          if (ent_rdata == vr_q) begin
            idx_d = i_q + CW'(1);
            state_d = S_OUT;
          end else begin
            state_d = S_WK;
          end
        end
      end
      S_WKB: begin
        if (cmp_res.lt) begin
          idx_d = i_q;
          state_d = S_OUT;
        end else begin
          i_d = i_q + CW'(1);
          cur_d = nxt_q;
          first_d = 1'b0;
          if (cmp_res.eq) begin
            idx_d = i_q + CW'(1);
            state_d = S_OUT;
          end else begin
            state_d = S_WK;
          end
        end
      end
      S_OUT: begin
        if (m_axis_tready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_mode_q <= '0;
      special_q <= '1;
      cache_limit_q <= iitl_pkg::CACHE_LIMIT_BITS'(4099);
      bound_zero_q <= '0;
      bound_one_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        iitl_pkg::REG_SIDE_MODE: side_mode_q <= cfg_data_i[iitl_pkg::SIDE_MODE_BITS-1:0];
        iitl_pkg::REG_SPECIAL_VALUE: special_q <= cfg_data_i;
        iitl_pkg::REG_CACHE_LIMIT: cache_limit_q <= cfg_data_i[iitl_pkg::CACHE_LIMIT_BITS-1:0];
        iitl_pkg::REG_PRIME_BOUND_ZERO: bound_zero_q <= cfg_data_i;
        iitl_pkg::REG_PRIME_BOUND_ONE: bound_one_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      cnt_q <= '0;
      seen_q <= 1'b0;
      fu_idx_q <= '0;
      fu_prime_q <= VW'({FB{1'b1}});
      bidx_q[0] <= '0;
      bidx_q[1] <= '0;
      bprime_q[0] <= '0;
      bprime_q[1] <= '0;
      clr_q <= '0;
      clr_resp_q <= 1'b0;
      idx_q <= '0;
      status_q <= iitl_pkg::ST_OK;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      seen_q <= seen_d;
      fu_idx_q <= fu_idx_d;
      fu_prime_q <= fu_prime_d;
      bidx_q <= bidx_d;
      bprime_q <= bprime_d;
      clr_q <= clr_d;
      clr_resp_q <= clr_resp_d;
      idx_q <= idx_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    p_q <= p_d;
    r_q <= r_d;
    side_q <= side_d;
    vp_q <= vp_d;
    vr_q <= vr_d;
    cur_q <= cur_d;
    nxt_q <= nxt_d;
    last_q <= last_d;
    i_q <= i_d;
    lo_q <= lo_d;
    hi_q <= hi_d;
    old_q <= old_d;
    step_q <= step_d;
    first_q <= first_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("Input accepted while a result is pending.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(2 ** TW))
    else $error("Entry count beyond table depth.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (s_axis_tuser == iitl_pkg::OP_CLEAR) |=> (state_q == S_CLR) && (cnt_q == '0))
    else $error("Clear did not start the cache sweep.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (status_q != iitl_pkg::ST_OK) |-> (idx_q == '0))
    else $error("Nonzero index reported with an error status.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("Pending item changed before it was taken.");

endmodule

FILE: rtl/core/iitl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module iitl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/core/iitl_cmp.sv
// Shared magnitude and equality compare unit used by the sequencer.
module iitl_cmp #(
  parameter int W = 32
) (
  input  logic [W-1:0]      a_i,
  input  logic [W-1:0]      b_i,
  output iitl_pkg::cmp_res_t res_o
);

  assign res_o.lt = (a_i < b_i);
  assign res_o.eq = (a_i == b_i);

endmodule
